// ===== rtl/skt_pkg.sv =====
`default_nettype none
package skt_pkg;

    localparam int KEY_W  = 32;
    localparam int STAT_W = 3;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CMP,
        OP_INS,
        OP_REM
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic signed [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic                    valid;
        logic                    ge;
        logic                    eq;
        logic                    m;
        logic signed [KEY_W-1:0] key;
    } t_cell_out;

endpackage
`default_nettype wire

// ===== rtl/skt_cell.sv =====
`default_nettype none
module skt_cell
    import skt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_cmd,
    input  wire t_cell_out i_left,
    input  wire t_cell_out i_right,
    output t_cell_out      o_cell
);

    logic                    r_valid;
    logic                    r_ge;
    logic                    r_eq;
    logic signed [KEY_W-1:0] r_key;

    logic                    n_valid;
    logic                    n_ge;
    logic                    n_eq;
    logic signed [KEY_W-1:0] n_key;
    logic                    w_m;

    // key belongs at or before this cell
    assign w_m = r_ge || !r_valid;

    always_comb begin
        n_valid = r_valid;
        n_ge    = r_ge;
        n_eq    = r_eq;
        n_key   = r_key;
        unique case (i_cmd.op)
            OP_CMP: begin
                n_ge = r_valid && (r_key >= i_cmd.key);
                n_eq = r_valid && (r_key == i_cmd.key);
            end
            OP_INS: begin
                if (i_left.m) begin
                    n_key   = i_left.key;
                    n_valid = i_left.valid;
                end else if (w_m) begin
                    n_key   = i_cmd.key;
                    n_valid = 1'b1;
                end
            end
            OP_REM: begin
                if (r_ge) begin
                    n_key   = i_right.key;
                    n_valid = i_right.valid;
                end
            end
            OP_NONE: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ge    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_ge    <= n_ge;
            r_eq    <= n_eq;
        end
        r_key <= n_key;
    end

    assign o_cell.valid = r_valid;
    assign o_cell.ge    = r_ge;
    assign o_cell.eq    = r_eq;
    assign o_cell.m     = w_m;
    assign o_cell.key   = r_key;

endmodule
`default_nettype wire

// ===== rtl/sorted_key_table.sv =====
`default_nettype none
// flow: the input is accepted only when idle, so one item completes before the next
// is taken; the cell row compares on accept and shifts on commit, and the result is
// registered on commit; a stalled output holds off the commit and the shift
// reset: synchronous active low, all cells invalid and count zero at once
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_s_axis_tvalid,
    output logic                                            o_s_axis_tready,
    input  wire logic [KEY_W-1:0]                           i_s_axis_tdata, // key_value
    input  wire logic                                       i_s_axis_tuser, // kind
    output logic                                            o_m_axis_tvalid,
    input  wire logic                                       i_m_axis_tready,
    // status, count, smallest_key, zero pad
    output logic [((STAT_W+$clog2(DEPTH+1)+KEY_W+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RES_W = STAT_W + CNT_W + KEY_W;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic {
        S_IDLE,
        S_CMP
    } t_state;

    t_state                  r_state;
    logic                    r_kind;
    logic signed [KEY_W-1:0] r_key;
    logic [CNT_W-1:0]        r_count;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;

    logic [CNT_W-1:0]        n_count;
    t_status                 n_status;
    logic signed [KEY_W-1:0] n_smallest;

    t_cmd                    w_cmd;
    t_cell_out               w_cell [DEPTH];
    t_cell_out               w_tie_left;
    t_cell_out               w_tie_right;
    logic [DEPTH-1:0]        w_valid;
    logic [DEPTH-1:0]        w_eq;
    logic                    w_accept;
    logic                    w_commit;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_found;

    assign w_tie_left  = '{valid: 1'b1, ge: 1'b0, eq: 1'b0, m: 1'b0, key: '0};
    assign w_tie_right = '{valid: 1'b0, ge: 1'b0, eq: 1'b0, m: 1'b1, key: '0};

    assign o_s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_commit        = (r_state == S_CMP) && (!r_out_valid || i_m_axis_tready);

    assign w_full  = w_valid[DEPTH-1];
    assign w_empty = !w_valid[0];
    assign w_found = |w_eq;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_out w_left;
        t_cell_out w_right;
        if (g == 0) begin : g_first
            assign w_left = w_tie_left;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_tie_right;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        skt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_cell  (w_cell[g])
        );
        assign w_valid[g] = w_cell[g].valid;
        assign w_eq[g]    = w_cell[g].eq;
    end

    always_comb begin
        w_cmd.op   = OP_NONE;
        w_cmd.key  = r_key;
        n_count    = r_count;
        n_status   = ST_NOT_FOUND;
        n_smallest = w_cell[0].valid ? w_cell[0].key : '0;
        if (w_accept) begin
            w_cmd.op  = OP_CMP;
            w_cmd.key = $signed(i_s_axis_tdata);
        end else if (w_commit) begin
            if (r_kind == KIND_INSERT) begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.op   = OP_INS;
                    n_status   = ST_INSERTED;
                    n_count    = r_count + CNT_W'(1);
                    n_smallest = w_cell[0].m ? r_key : w_cell[0].key;
                end
            end else begin
                priority if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (w_found) begin
                    w_cmd.op = OP_REM;
                    n_status = ST_REMOVED;
                    n_count  = r_count - CNT_W'(1);
                    if (w_cell[0].ge) begin
                        n_smallest = w_cell[1].valid ? w_cell[1].key : '0;
                    end
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_kind <= i_s_axis_tuser;
            r_key  <= $signed(i_s_axis_tdata);
        end
        if (w_commit) begin
            r_out_data <= OUT_W'({n_smallest, n_count, n_status});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // stored count agrees with the occupied cells
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("count differs from occupied cells");

    // occupied cells form an unbroken run from the front of the row
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + DEPTH'(1)) & w_valid) == '0)
        else $error("gap in occupied cells");

    // the row only changes on the commit cycle
    a_row_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_commit |=> $stable(w_valid))
        else $error("row changed outside commit");

    // a removal that found its key shrinks the table by one
    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_REM) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("removal did not shrink table");

endmodule
`default_nettype wire
